[rtl/range_or_update_and_query_tree_core_assert.svh]
// ----------------------------------------------------------------------------
// Range OR / AND tree core - assertion macros
// Concurrent checks on posedge clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef RANGE_OR_UPDATE_AND_QUERY_TREE_CORE_ASSERT_SVH
`define RANGE_OR_UPDATE_AND_QUERY_TREE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define RQT_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("rqt assertion failed");
`define RQT_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("rqt assertion failed");
`else
`define RQT_ASSERT_IMP(lbl, a, c)
`define RQT_ASSERT_NXT(lbl, a, c)
`endif
`endif

[rtl/rqt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rqt_pkg
// Types and constants shared by the range OR / AND tree core.
// ----------------------------------------------------------------------------
package rqt_pkg;

  localparam int LEAVES  = 1024;
  localparam int NODES   = 2 * LEAVES;
  localparam int NODE_W  = $clog2(NODES);
  localparam int POS_W   = $clog2(LEAVES);
  localparam int SIZE_W  = 11;
  localparam int WORD_W  = 64;
  localparam int STK_D   = POS_W + 1;
  localparam int SP_W    = $clog2(STK_D + 1);

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  typedef struct packed {
    logic [WORD_W-1:0] val;   // AND of the node's span
    logic [WORD_W-1:0] por;   // pending OR for the node
  } node_t;

  typedef struct packed {
    logic              en;
    logic [NODE_W-1:0] addr;
    node_t             data;
  } mem_wr_t;

  typedef struct packed {
    logic [NODE_W-1:0] k;
    logic [POS_W-1:0]  s;
    logic [POS_W-1:0]  e;
    logic              right;  // left child done, right child in progress
  } frame_t;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_RD, S_EVAL, S_C0RD, S_C0WR, S_C1RD, S_C1WR,
    S_DEC, S_RET, S_J0, S_J1, S_JW, S_OUT
  } state_t;

endpackage
`default_nettype wire

[rtl/rqt_node_mem.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rqt_node_mem
// Tree node store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rqt_node_mem
  import rqt_pkg::*;
(
  input  wire logic              clk,
  input  wire mem_wr_t           wr,
  input  wire logic              rd_en,
  input  wire logic [NODE_W-1:0] rd_addr,
  output node_t                  rd_data
);

  node_t mem [NODES];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

[rtl/range_or_update_and_query_tree_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// range_or_update_and_query_tree_core
// Lazy segment tree over 1024 64-bit words: range OR update, range AND query.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  in_     | in  | tvalid/tready      | tuser: op; tdata: lo, hi, or_value
//  out_    | out | tvalid/tready      | tdata: and_result
//  cfg_    | in  | APB psel/penable   | reg 0: size_in_use (11 bits)
//
// One item walks the tree depth first through a single node memory (one read
// port, one write port): each visited node is read, evaluated, decided on and
// returned from; a pending OR is moved down to both children (read and write
// each), and on update each split node is rebuilt from its two children.
// A query then loads its result into the output register; ready is low meanwhile.
// After reset a clearing pass writes all 2048 nodes, with no
// word accepted meanwhile; config writes are taken at any time.
// A query result waits in the output register; the next word is accepted
// once the result is loaded.
// ----------------------------------------------------------------------------
`include "range_or_update_and_query_tree_core_assert.svh"
module range_or_update_and_query_tree_core
  import rqt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [87:0] in_tdata,   // [9:0] range_low, [19:10] range_high,
                                        // [83:20] or_value, [87:84] zero
  input  wire logic [0:0]  in_tuser,   // [0] op
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // [63:0] and_result
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  state_t            state_r, state_nxt;
  logic [SIZE_W-1:0] size_r;
  logic [NODE_W-1:0] clr_cnt_r;
  logic [NODE_W-1:0] cur_k_r;
  logic [POS_W-1:0]  cur_s_r, cur_e_r;
  logic [SP_W-1:0]   sp_r;
  frame_t            stk_r [STK_D];
  logic              op_r;
  logic [POS_W-1:0]  lo_r, hi_r;
  logic [WORD_W-1:0] v_r, acc_r, x_r, val0_r;
  logic              disj_r, cov_r;
  logic              out_valid_r;
  logic [WORD_W-1:0] out_data_r;

  mem_wr_t           wr;
  logic              rd_en;
  logic [NODE_W-1:0] rd_addr;
  node_t             rd_data;

  rqt_node_mem u_mem (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // config
  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : {{(32-SIZE_W){1'b0}}, size_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_W'(LEAVES);
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && !cfg_paddr[2]) begin
      size_r <= cfg_pwdata[SIZE_W-1:0];
    end
  end

  logic [POS_W-1:0] last_pos;
  always_comb begin
    if (size_r == '0) begin
      last_pos = '0;
    end else if (size_r > SIZE_W'(LEAVES)) begin
      last_pos = POS_W'(LEAVES - 1);
    end else begin
      last_pos = POS_W'(size_r - SIZE_W'(1));
    end
  end

  // node evaluation
  logic              ev_disj, ev_cov;
  logic [WORD_W-1:0] ev_ov, ev_val, ev_x;
  assign ev_disj = (cur_s_r > hi_r) || (cur_e_r < lo_r);
  assign ev_cov  = (lo_r <= cur_s_r) && (cur_e_r <= hi_r);
  assign ev_ov   = (ev_cov && op_r == OP_UPDATE) ? v_r : '0;
  assign ev_val  = rd_data.val | rd_data.por | ev_ov;
  assign ev_x    = rd_data.por | ev_ov;

  logic [POS_W:0]    cur_sum;
  logic [POS_W-1:0]  cur_mid;
  assign cur_sum = {1'b0, cur_s_r} + {1'b0, cur_e_r};
  assign cur_mid = cur_sum[POS_W:1];

  frame_t            top;
  logic [POS_W:0]    top_sum;
  logic [POS_W-1:0]  top_mid;
  assign top     = stk_r[sp_r - SP_W'(1)];
  assign top_sum = {1'b0, top.s} + {1'b0, top.e};
  assign top_mid = top_sum[POS_W:1];

  logic in_acc;
  assign in_acc = in_tvalid && in_tready;

  logic out_load;
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_tready);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLR:  if (clr_cnt_r == NODE_W'(NODES - 1)) state_nxt = S_IDLE;
      S_IDLE: if (in_acc) state_nxt = S_RD;
      S_RD:   state_nxt = S_EVAL;
      S_EVAL: state_nxt = (cur_s_r != cur_e_r && ev_x != '0) ? S_C0RD : S_DEC;
      S_C0RD: state_nxt = S_C0WR;
      S_C0WR: state_nxt = S_C1RD;
      S_C1RD: state_nxt = S_C1WR;
      S_C1WR: state_nxt = S_DEC;
      S_DEC:  state_nxt = (disj_r || cov_r) ? S_RET : S_RD;
      S_RET: begin
        if (sp_r == '0) begin
          state_nxt = (op_r == OP_QUERY) ? S_OUT : S_IDLE;
        end else if (!top.right) begin
          state_nxt = S_RD;
        end else if (op_r == OP_UPDATE) begin
          state_nxt = S_J0;
        end
      end
      S_J0:   state_nxt = S_J1;
      S_J1:   state_nxt = S_JW;
      S_JW:   state_nxt = S_RET;
      S_OUT:  if (!out_valid_r || out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // memory control and ready
  always_comb begin
    in_tready    = (state_r == S_IDLE);
    wr.en        = 1'b0;
    wr.addr      = cur_k_r;
    wr.data.val  = '0;
    wr.data.por  = '0;
    rd_en        = 1'b0;
    rd_addr      = cur_k_r;
    case (state_r)
      S_CLR: begin
        wr.en   = 1'b1;
        wr.addr = clr_cnt_r;
      end
      S_RD: rd_en = 1'b1;
      S_EVAL: begin
        wr.en       = 1'b1;
        wr.data.val = ev_val;
      end
      S_C0RD, S_J0: begin
        rd_en   = 1'b1;
        rd_addr = {cur_k_r[NODE_W-2:0], 1'b0};
      end
      S_C1RD, S_J1: begin
        rd_en   = 1'b1;
        rd_addr = {cur_k_r[NODE_W-2:0], 1'b1};
      end
      S_C0WR: begin
        wr.en       = 1'b1;
        wr.addr     = {cur_k_r[NODE_W-2:0], 1'b0};
        wr.data.val = rd_data.val;
        wr.data.por = rd_data.por | x_r;
      end
      S_C1WR: begin
        wr.en       = 1'b1;
        wr.addr     = {cur_k_r[NODE_W-2:0], 1'b1};
        wr.data.val = rd_data.val;
        wr.data.por = rd_data.por | x_r;
      end
      S_JW: begin
        wr.en       = 1'b1;
        wr.data.val = val0_r & rd_data.val;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      sp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLR) begin
        clr_cnt_r <= clr_cnt_r + NODE_W'(1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: if (in_acc) sp_r <= '0;
        S_DEC: begin
          if (!(disj_r || cov_r)) begin
            sp_r <= sp_r + SP_W'(1);
          end
        end
        S_RET: begin
          if (sp_r != '0 && top.right) begin
            sp_r <= sp_r - SP_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_r    <= in_tuser[0];
          lo_r    <= in_tdata[9:0];
          hi_r    <= in_tdata[19:10];
          v_r     <= in_tdata[83:20];
          acc_r   <= '1;
          cur_k_r <= NODE_W'(1);
          cur_s_r <= '0;
          cur_e_r <= last_pos;
        end
      end
      S_EVAL: begin
        x_r    <= ev_x;
        disj_r <= ev_disj;
        cov_r  <= ev_cov;
        if (op_r == OP_QUERY && ev_cov && !ev_disj) begin
          acc_r <= acc_r & ev_val;
        end
      end
      S_DEC: begin
        if (!(disj_r || cov_r)) begin
          stk_r[sp_r[SP_W-1:0]] <= '{k: cur_k_r, s: cur_s_r, e: cur_e_r, right: 1'b0};
          cur_k_r <= {cur_k_r[NODE_W-2:0], 1'b0};
          cur_e_r <= cur_mid;
        end
      end
      S_RET: begin
        if (sp_r != '0) begin
          if (!top.right) begin
            stk_r[sp_r - SP_W'(1)].right <= 1'b1;
            cur_k_r <= {top.k[NODE_W-2:0], 1'b1};
            cur_s_r <= top_mid + POS_W'(1);
            cur_e_r <= top.e;
          end else begin
            cur_k_r <= top.k;
            cur_s_r <= top.s;
            cur_e_r <= top.e;
          end
        end
      end
      S_J1: val0_r <= rd_data.val;
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_data_r <= acc_r;
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `RQT_ASSERT_IMP(a_ready_only_idle, in_tready, state_r == S_IDLE)
  `RQT_ASSERT_NXT(a_eval_follows_rd, state_r == S_RD, state_r == S_EVAL)
  `RQT_ASSERT_IMP(a_stack_bound, state_r == S_DEC, sp_r < SP_W'(STK_D))
  `RQT_ASSERT_IMP(a_no_result_clearing, state_r == S_CLR, !out_tvalid)

endmodule
`default_nettype wire
